[hw/rtl/gcrtfd_pkg.sv]
`timescale 1ns / 1ps

package gcrtfd_pkg;

  localparam int unsigned WORD_W   = 20;
  localparam int unsigned SYM_W    = 5;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned MANT_W   = 9;
  localparam int unsigned EXPO_W   = 3;

  localparam logic [11:0] PERIOD_STOP = 12'hFFF;

  typedef struct packed {
    logic       legal;
    logic [3:0] nib;
  } gcr_sym_t;

  typedef struct packed {
    logic                frame_valid;
    logic [PERIOD_W-1:0] period_micros;
  } gcr_result_t;

  // GCR 5b -> 4b code table; anything else is an illegal symbol.
  function automatic gcr_sym_t gcr_lookup(input logic [SYM_W-1:0] sym);
    gcr_sym_t r;
    r.legal = 1'b1;
    unique case (sym)
      5'h19:   r.nib = 4'h0;
      5'h1B:   r.nib = 4'h1;
      5'h12:   r.nib = 4'h2;
      5'h13:   r.nib = 4'h3;
      5'h1D:   r.nib = 4'h4;
      5'h15:   r.nib = 4'h5;
      5'h16:   r.nib = 4'h6;
      5'h17:   r.nib = 4'h7;
      5'h1A:   r.nib = 4'h8;
      5'h09:   r.nib = 4'h9;
      5'h0A:   r.nib = 4'hA;
      5'h0B:   r.nib = 4'hB;
      5'h1E:   r.nib = 4'hC;
      5'h0D:   r.nib = 4'hD;
      5'h0E:   r.nib = 4'hE;
      5'h0F:   r.nib = 4'hF;
      default: begin
        r.legal = 1'b0;
        r.nib   = 4'h0;
      end
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/gcr_telemetry_frame_decoder.sv]
`timescale 1ns / 1ps
// Telemetry word decoder for bidirectional GCR-coded replies.
// Input channel (s_axis_*): one beat carries one received 20-bit word, first
// GCR symbol in bits 19..15. Output channel (m_axis_*): one beat per input
// beat, in order; tdata holds the period in microseconds, tuser flags a good
// frame (all symbols legal and checksum matching). Bad frames and the stop
// code both report period 0; only the flag tells them apart.
// Pipeline: one input register, the symbol lookup and period shift, then the
// output register.
// Throughput: one word per cycle unless stalled; the input and the output
// register each advance whenever the stage after them is empty or draining,
// so a new beat is taken while a finished result still waits at the output.
// Stall: while m_axis_tready is low the output beat holds; the input register
// fills behind it and then s_axis_tready drops until the output drains.
// Reset (rst, synchronous): both stages are emptied; no output beat is shown
// until new input arrives. The data registers are not cleared.

module gcr_telemetry_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [19:0] raw_symbols, [23:20] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] period in microseconds
  output logic        m_axis_tuser    // [0] frame_valid
);
  import gcrtfd_pkg::*;

  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              out_valid;
  gcr_result_t       out_result;
  gcr_result_t       dec_result;
  logic              in_advance;
  logic              s_accept;

  assign in_advance    = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || in_advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  gcrtfd_decode u_decode (
    .word   (in_word),
    .result (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (in_advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_word <= s_axis_tdata[WORD_W-1:0];
    end
    if (in_advance && in_valid) begin
      out_result <= dec_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result.period_micros;
  assign m_axis_tuser  = out_result.frame_valid;

endmodule

[hw/rtl/gcrtfd_decode.sv]
`timescale 1ns / 1ps

module gcrtfd_decode (
  input  logic [gcrtfd_pkg::WORD_W-1:0] word,
  output gcrtfd_pkg::gcr_result_t       result
);
  import gcrtfd_pkg::*;

  gcr_sym_t                 sym0, sym1, sym2, sym3;
  logic [NIB_W-1:0]         raw0, raw1, raw2, raw3;
  logic [11:0]              period12;
  logic [NIB_W-1:0]         calc_sum;
  logic                     legal;
  logic [EXPO_W-1:0]        expo;
  logic [MANT_W-1:0]        mant;
  logic [PERIOD_W-1:0]      shifted;

  assign sym0 = gcr_lookup(word[19:15]);
  assign sym1 = gcr_lookup(word[14:10]);
  assign sym2 = gcr_lookup(word[9:5]);
  assign sym3 = gcr_lookup(word[4:0]);

  // undo the whitening: each raw nibble folds in the one before it
  assign raw0 = sym0.nib;
  assign raw1 = sym1.nib ^ raw0;
  assign raw2 = sym2.nib ^ raw1;
  assign raw3 = sym3.nib ^ raw2;

  assign period12 = {raw0, raw1, raw2};
  assign calc_sum = ~(raw0 ^ raw1 ^ raw2);
  assign legal    = sym0.legal & sym1.legal & sym2.legal & sym3.legal;

  assign expo    = period12[11:9];
  assign mant    = period12[8:0];
  assign shifted = {{(PERIOD_W-MANT_W){1'b0}}, mant} << expo;

  always_comb begin
    result.frame_valid   = legal && (calc_sum == raw3);
    result.period_micros = '0;
    if (result.frame_valid && (period12 != PERIOD_STOP)) begin
      result.period_micros = shifted;
    end
  end

endmodule

[hw/rtl/gcrtfd_checker.sv]
`timescale 1ns / 1ps

module gcrtfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // a bad frame never reports a period
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'h0000)
    else $error("invalid frame with nonzero period");

  // an accepted beat reaches the output register when not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after accepted beat");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // input may be refused only while the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused with output free");

endmodule

bind gcr_telemetry_frame_decoder gcrtfd_checker u_gcrtfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
